// ----- src/ctne_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctne_pkg
// shared constants for the cube texel normal encoder
// ----------------------------------------------------------------------------
package ctne_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // cube size register
  localparam int               CFG_BITS        = 13;
  localparam logic [12:0]      FACE_SIZE_RESET = 13'd128;

  // face codes
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // byte encoding: c*127 + 128
  localparam logic [7:0] BYTE_BIAS = 8'd128;

endpackage

// ----- src/ctne_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctne_div
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
module ctne_div #(
  parameter int DW    = 13,
  parameter int QW    = 17,
  parameter int LANES = 2,
  parameter int PW    = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [DW-1:0]               in_den,
  input  logic [LANES-1:0][DW-1:0]    in_rem,
  input  logic [PW-1:0]               in_pay,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    out_quo,
  output logic [PW-1:0]               out_pay
);

  logic                     vld [0:QW];
  logic [DW-1:0]            den [0:QW];
  logic [LANES-1:0][DW-1:0] rem [0:QW];
  logic [LANES-1:0][QW-1:0] quo [0:QW];
  logic [PW-1:0]            pay [0:QW];

  assign vld[0] = in_valid;
  assign den[0] = in_den;
  assign rem[0] = in_rem;
  assign quo[0] = '0;
  assign pay[0] = in_pay;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] quo_next;

    always_comb begin
      logic [DW:0] r2;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        r2 = {rem[k][l], 1'b0};
        ge = (r2 >= {1'b0, den[k]});
        rem_next[l] = ge ? DW'(r2 - {1'b0, den[k]}) : r2[DW-1:0];
        quo_next[l] = {quo[k][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den[k+1] <= den[k];
        rem[k+1] <= rem_next;
        quo[k+1] <= quo_next;
        pay[k+1] <= pay[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_pay   = pay[QW];

endmodule

// ----- src/ctne_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctne_isqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module ctne_isqrt #(
  parameter int LW = 34,
  parameter int SW = 17,
  parameter int PW = 54
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [LW-1:0] in_val,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [SW-1:0] out_root,
  output logic [PW-1:0] out_pay
);

  logic          vld [0:SW];
  logic [LW-1:0] rem [0:SW];
  logic [SW-1:0] res [0:SW];
  logic [PW-1:0] pay [0:SW];

  assign vld[0] = in_valid;
  assign rem[0] = in_val;
  assign res[0] = '0;
  assign pay[0] = in_pay;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam int B = SW - 1 - k;
    logic [LW:0]   trial;
    logic          ge;
    logic [LW-1:0] rem_next;
    logic [SW-1:0] res_next;

    // (res + 2^B)^2 - res^2 = res*2^(B+1) + 2^(2B)
    assign trial    = ((LW+1)'(res[k]) << (B + 1)) + ((LW+1)'(1) << (2 * B));
    assign ge       = ({1'b0, rem[k]} >= trial);
    assign rem_next = ge ? LW'({1'b0, rem[k]} - trial) : rem[k];
    assign res_next = ge ? (res[k] | (SW'(1) << B)) : res[k];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= rem_next;
        res[k+1] <= res_next;
        pay[k+1] <= pay[k];
      end
    end
  end

  assign out_valid = vld[SW];
  assign out_root  = res[SW];
  assign out_pay   = pay[SW];

endmodule

// ----- src/cube_texel_normal_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_texel_normal_encoder
// normalization cube map texel: face and texel position to encoded normal
// ----------------------------------------------------------------------------
// Input channel texel_valid/texel_stall carries face, texel_column and
// texel_row; a transaction happens when valid is high and stall is low.
// Output channel result_valid/result_stall carries x_byte, y_byte, z_byte,
// one result per input, in order.
// face_size is written over cfg_valid/cfg_ready/cfg_data (always ready) and
// may only change while the pipeline is empty.
// The pipeline has a clamp stage, the face coordinate divider and the
// square root and reciprocal units, one stage per result bit each, plus
// stages for the vector, squares, sum, multiply and encode. One texel is
// taken every cycle while the output is not stalled.
// When the output is stalled the whole pipeline holds, and texel_stall is
// raised in the same cycle. Synchronous reset empties the pipeline and sets
// face_size to 128.
// ----------------------------------------------------------------------------
module cube_texel_normal_encoder #(
  parameter int COORD_BITS = ctne_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = ctne_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ctne_pkg::CFG_BITS-1:0] cfg_data,
  input  logic                          texel_valid,
  output logic                          texel_stall,
  input  logic [2:0]                    face,
  input  logic [COORD_BITS-1:0]         texel_column,
  input  logic [COORD_BITS-1:0]         texel_row,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    x_byte,
  output logic [7:0]                    y_byte,
  output logic [7:0]                    z_byte
);
  import ctne_pkg::*;

  localparam int SZ   = COORD_BITS + 1;
  localparam int WIDE = CFG_BITS + COORD_BITS + 1;
  localparam int QW   = FRAC_BITS + 1;
  localparam int VW   = FRAC_BITS + 2;
  localparam int LW   = 2 * FRAC_BITS + 2;
  localparam int PRW  = 2 * VW;
  localparam int EW   = PRW + 7;
  localparam logic signed [VW-1:0] ONE = VW'(1) << FRAC_BITS;

  logic adv;
  assign adv         = !(result_valid && result_stall);
  assign texel_stall = !adv;
  assign cfg_ready   = 1'b1;

  logic [CFG_BITS-1:0] face_size;
  always_ff @(posedge clk) begin
    if (rst) begin
      face_size <= FACE_SIZE_RESET;
    end else if (cfg_valid) begin
      face_size <= cfg_data;
    end
  end

  // clamp size and coordinates
  logic [WIDE-1:0] sz_w;
  logic [SZ-1:0]   size_eff;
  logic [COORD_BITS-1:0] col_c, row_c;
  assign sz_w = WIDE'(face_size);
  always_comb begin
    if (face_size == '0) begin
      size_eff = SZ'(1);
    end else if (sz_w > (WIDE'(1) << COORD_BITS)) begin
      size_eff = SZ'(1) << COORD_BITS;
    end else begin
      size_eff = SZ'(face_size);
    end
    col_c = ({1'b0, texel_column} >= size_eff) ? COORD_BITS'(size_eff - SZ'(1))
                                                : texel_column;
    row_c = ({1'b0, texel_row} >= size_eff) ? COORD_BITS'(size_eff - SZ'(1))
                                             : texel_row;
  end

  logic                  s0_valid;
  logic [2:0]            s0_face;
  logic [SZ-1:0]         s0_size;
  logic [COORD_BITS-1:0] s0_col, s0_row;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= texel_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_face <= face;
      s0_size <= size_eff;
      s0_col  <= col_c;
      s0_row  <= row_c;
    end
  end

  // face coordinates: floor(2*idx*2^F / size)
  logic                 cd_valid;
  logic [1:0][QW-1:0]   cd_quo;
  logic [2:0]           cd_face;
  logic [1:0][SZ-1:0]   cd_rem;
  assign cd_rem[0] = {1'b0, s0_col};
  assign cd_rem[1] = {1'b0, s0_row};

  ctne_div #(
    .DW(SZ), .QW(QW), .LANES(2), .PW(3)
  ) u_coord_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s0_valid),
    .in_den   (s0_size),
    .in_rem   (cd_rem),
    .in_pay   (s0_face),
    .out_valid(cd_valid),
    .out_quo  (cd_quo),
    .out_pay  (cd_face)
  );

  // direction vector
  logic signed [VW-1:0] sc, tc, vx, vy, vz;
  assign sc = $signed({1'b0, cd_quo[0]}) - ONE;
  assign tc = $signed({1'b0, cd_quo[1]}) - ONE;
  always_comb begin
    case (cd_face)
      FACE_POS_X: begin vx = ONE;  vy = -tc;  vz = -sc;  end
      FACE_NEG_X: begin vx = -ONE; vy = -tc;  vz = sc;   end
      FACE_POS_Y: begin vx = sc;   vy = ONE;  vz = tc;   end
      FACE_NEG_Y: begin vx = sc;   vy = -ONE; vz = -tc;  end
      FACE_POS_Z: begin vx = sc;   vy = -tc;  vz = ONE;  end
      FACE_NEG_Z: begin vx = -sc;  vy = -tc;  vz = -ONE; end
      // unused faces give a zero vector, which encodes as the bias
      default:    begin vx = '0;   vy = '0;   vz = '0;   end
    endcase
  end

  logic                 s1_valid, s2_valid, s3_valid;
  logic [3*VW-1:0]      s1_vec, s2_vec, s3_vec;
  logic [LW-1:0]        s2_sqx, s2_sqy, s2_sqz, s3_len2;
  logic signed [PRW-1:0] prx, pry, prz;

  assign prx = $signed(s1_vec[3*VW-1:2*VW]) * $signed(s1_vec[3*VW-1:2*VW]);
  assign pry = $signed(s1_vec[2*VW-1:VW]) * $signed(s1_vec[2*VW-1:VW]);
  assign prz = $signed(s1_vec[VW-1:0]) * $signed(s1_vec[VW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cd_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vec  <= {vx, vy, vz};
      s2_vec  <= s1_vec;
      s2_sqx  <= prx[LW-1:0];
      s2_sqy  <= pry[LW-1:0];
      s2_sqz  <= prz[LW-1:0];
      s3_vec  <= s2_vec;
      s3_len2 <= s2_sqx + s2_sqy + s2_sqz;
    end
  end

  // vector length
  logic            sq_valid;
  logic [QW-1:0]   sq_root;
  logic [3*VW-1:0] sq_vec;

  ctne_isqrt #(
    .LW(LW), .SW(QW), .PW(3*VW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s3_valid),
    .in_val   (s3_len2),
    .in_pay   (s3_vec),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_pay  (sq_vec)
  );

  // reciprocal length: floor(2^(2F) / s)
  logic                rc_valid;
  logic [0:0][QW-1:0]  rc_quo;
  logic [3*VW-1:0]     rc_vec;
  logic [0:0][QW-1:0]  rc_rem;
  assign rc_rem[0] = QW'(1) << (FRAC_BITS - 1);

  ctne_div #(
    .DW(QW), .QW(QW), .LANES(1), .PW(3*VW)
  ) u_recip_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (sq_valid),
    .in_den   (sq_root),
    .in_rem   (rc_rem),
    .in_pay   (sq_vec),
    .out_valid(rc_valid),
    .out_quo  (rc_quo),
    .out_pay  (rc_vec)
  );

  // scale each component by the reciprocal
  logic                  s4_valid;
  logic signed [PRW-1:0] s4_px, s4_py, s4_pz;
  logic signed [VW-1:0]  r_s;
  assign r_s = $signed({1'b0, rc_quo[0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= rc_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_px <= $signed(rc_vec[3*VW-1:2*VW]) * r_s;
      s4_py <= $signed(rc_vec[2*VW-1:VW]) * r_s;
      s4_pz <= $signed(rc_vec[VW-1:0]) * r_s;
    end
  end

  // times 127 as (p << 7) - p, floor shift, then bias
  function automatic logic [7:0] enc_byte(input logic signed [PRW-1:0] p);
    logic signed [EW-1:0] e;
    logic signed [EW-1:0] q;
    e = (EW'(p) <<< 7) - EW'(p);
    q = e >>> (2 * FRAC_BITS);
    return q[7:0] + BYTE_BIAS;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s4_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x_byte <= enc_byte(s4_px);
      y_byte <= enc_byte(s4_py);
      z_byte <= enc_byte(s4_pz);
    end
  end

endmodule

// ----- src/ctne_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctne_checker
// port level checks for the cube texel normal encoder
// ----------------------------------------------------------------------------
module ctne_checker (
  input logic       clk,
  input logic       rst,
  input logic       texel_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] x_byte,
  input logic [7:0] y_byte,
  input logic [7:0] z_byte
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(x_byte) && $stable(y_byte) && $stable(z_byte))
    else $error("stalled result changed");

  // input backpressure follows output backpressure
  a_stall: assert property (@(posedge clk) disable iff (rst)
    texel_stall == (result_valid && result_stall))
    else $error("texel_stall mismatch");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result after reset");

  // encoded components never reach zero
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> x_byte != 8'd0 && y_byte != 8'd0 && z_byte != 8'd0)
    else $error("encoded byte out of range");

endmodule

bind cube_texel_normal_encoder ctne_checker u_ctne_checker (.*);
